// File: rtl/ipv4_prefix_acl_table_defines.svh
// Assertion helpers used by ipal_ctrl. Every use expects signals named clk and
// rst_n in the enclosing module.
`ifndef IPV4_PREFIX_ACL_TABLE_DEFINES_SVH
`define IPV4_PREFIX_ACL_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ipal_pkg.sv
`default_nettype none

package ipal_pkg;

  localparam int ADDR_W = 32;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DUP       = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [5:0]        prefix_len;
  } in_req_t;

  typedef struct packed {
    status_t    status;
    logic [4:0] rule_count;
  } out_rsp_t;

  // Request travelling down the chain of rule cells.
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] base;
    logic              hit;
  } token_t;

  // Rule write broadcast to the cells; the selected cell takes it.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mask;
  } rule_wr_t;

  // Prefix lengths above the address width saturate to a full host mask.
  function automatic logic [ADDR_W-1:0] mask_of_prefix(input logic [5:0] plen);
    logic [5:0] sat;
    sat = (plen > 6'(ADDR_W)) ? 6'(ADDR_W) : plen;
    if (sat == 6'd0) begin
      return '0;
    end
    return {ADDR_W{1'b1}} << (6'(ADDR_W) - sat);
  endfunction

endpackage

`default_nettype wire

// File: rtl/ipal_cell.sv
`default_nettype none

module ipal_cell #(
  parameter int IDX     = 0,
  parameter int COUNT_W = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [COUNT_W-1:0]   count,
  input  wire ipal_pkg::rule_wr_t   wr,
  input  wire logic                 wr_sel,
  input  wire ipal_pkg::token_t     tok_i,
  output      ipal_pkg::token_t     tok_o
);

  logic [ipal_pkg::ADDR_W-1:0] base_r;
  logic [ipal_pkg::ADDR_W-1:0] mask_r;
  ipal_pkg::token_t            tok_r;
  ipal_pkg::token_t            tok_nxt;
  logic                        live;
  logic                        match;

  // Only entries below the rule count hold a rule.
  assign live = (COUNT_W'(IDX) < count);

  always_comb begin
    if (tok_i.kind == ipal_pkg::KIND_TEST) begin
      match = ((tok_i.address & mask_r) == base_r);
    end else begin
      match = (base_r == tok_i.base) && (mask_r == tok_i.mask);
    end
    tok_nxt     = tok_i;
    tok_nxt.hit = tok_i.hit | (live & match);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.kind    <= tok_nxt.kind;
    tok_r.address <= tok_nxt.address;
    tok_r.mask    <= tok_nxt.mask;
    tok_r.base    <= tok_nxt.base;
    tok_r.hit     <= tok_nxt.hit;
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_sel) begin
      base_r <= wr.base;
      mask_r <= wr.mask;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// File: rtl/ipal_ctrl.sv
`default_nettype none

`include "ipv4_prefix_acl_table_defines.svh"

module ipal_ctrl #(
  parameter int RULE_SLOTS = 16,
  parameter int COUNT_W    = 5,
  parameter int IDX_W      = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire ipal_pkg::in_req_t   in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      ipal_pkg::out_rsp_t  out_data,
  output      ipal_pkg::token_t    head,
  input  wire ipal_pkg::token_t    tail,
  output      logic [COUNT_W-1:0]  count,
  output      ipal_pkg::rule_wr_t  wr,
  output      logic [IDX_W-1:0]    wr_idx
);

  ipal_pkg::ctrl_state_t state_r, state_nxt;
  ipal_pkg::token_t      head_r, head_nxt;
  ipal_pkg::token_t      fin_r, fin_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ipal_pkg::out_rsp_t    out_data_r, out_data_nxt;
  logic [31:0]           count_ext;
  logic                  full;
  logic [ipal_pkg::ADDR_W-1:0] in_mask;

  assign full    = (count_r == COUNT_W'(RULE_SLOTS));
  assign in_mask = ipal_pkg::mask_of_prefix(in_data.prefix_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ipal_pkg::ST_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      head_r.valid <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      head_r.valid <= head_nxt.valid;
    end
    head_r.kind    <= head_nxt.kind;
    head_r.address <= head_nxt.address;
    head_r.mask    <= head_nxt.mask;
    head_r.base    <= head_nxt.base;
    head_r.hit     <= head_nxt.hit;
    fin_r          <= fin_nxt;
    out_data_r     <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    head_nxt.valid = 1'b0;
    fin_nxt       = fin_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    wr.en         = 1'b0;
    wr.base       = fin_r.base;
    wr.mask       = fin_r.mask;
    count_ext     = 32'(count_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ipal_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          head_nxt.valid   = 1'b1;
          head_nxt.kind    = in_data.kind;
          head_nxt.address = in_data.address;
          head_nxt.mask    = in_mask;
          head_nxt.base    = in_data.address & in_mask;
          head_nxt.hit     = 1'b0;
          state_nxt        = ipal_pkg::ST_SEARCH;
        end
      end
      ipal_pkg::ST_SEARCH: begin
        if (tail.valid) begin
          fin_nxt   = tail;
          state_nxt = ipal_pkg::ST_FINISH;
        end
      end
      ipal_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          if (fin_r.kind == ipal_pkg::KIND_TEST) begin
            out_data_nxt.status = fin_r.hit ? ipal_pkg::STAT_OK : ipal_pkg::STAT_NOT_FOUND;
          end else if (fin_r.hit) begin
            out_data_nxt.status = ipal_pkg::STAT_DUP;
          end else if (full) begin
            out_data_nxt.status = ipal_pkg::STAT_FULL;
          end else begin
            out_data_nxt.status = ipal_pkg::STAT_OK;
            wr.en               = 1'b1;
            count_nxt           = count_r + COUNT_W'(1);
            count_ext           = 32'(count_nxt);
          end
          out_data_nxt.rule_count = count_ext[4:0];
          out_valid_nxt           = 1'b1;
          state_nxt               = ipal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ipal_pkg::ST_IDLE;
      end
    endcase
  end

  assign head      = head_r;
  assign count     = count_r;
  assign wr_idx    = IDX_W'(count_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IPAL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= COUNT_W'(RULE_SLOTS),
                   "rule count exceeds table capacity")
  `IPAL_ASSERT_NOW(a_wr_not_full, wr.en, !full,
                   "rule written into a full table")
  `IPAL_ASSERT_NEXT(a_accept_starts, in_valid && in_ready,
                    state_r == ipal_pkg::ST_SEARCH && head_r.valid,
                    "accepted request did not enter the cell chain")
  `IPAL_ASSERT_NOW(a_tail_only_search, tail.valid, state_r == ipal_pkg::ST_SEARCH,
                   "chain produced a request outside the search phase")

endmodule

`default_nettype wire

// File: rtl/ipv4_prefix_acl_table.sv
`default_nettype none

// IPv4 prefix access list with room for RULE_SLOTS rules. An add request
// (kind 0) masks its address with the mask of its prefix length (0 gives an
// all-zero mask, lengths above 32 act as 32) and appends the rule unless an
// identical base and mask is already present (status 1) or the table is full
// (status 3). A test request (kind 1) reports status 0 when any stored rule
// covers the address and status 2 otherwise. Every request gives exactly one
// result carrying the rule count after that request. The rules live in a row
// of RULE_SLOTS cells; a request walks the row one cell per clock, each cell
// comparing it against its own rule and passing the accumulated hit on. One
// request is in flight at a time. It is registered at the head of the row,
// passes through the cells, is captured as it leaves the last cell, and then
// its status is settled, the rule appended and the result registered. The
// block is ready again in the cycle after that. A finished result waits in an
// output register, so the next request is accepted while it is still waiting
// to be taken; if that result is still waiting when the next one is settled,
// the block holds the new result, and takes no further request, until the
// output register is free. Rule entries need no clearing after reset; only
// entries below the rule count are used.
module ipv4_prefix_acl_table #(
  parameter int RULE_SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire ipal_pkg::in_req_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      ipal_pkg::out_rsp_t out_data
);

  // The count must reach RULE_SLOTS itself, so it needs one more code.
  localparam int COUNT_W = $clog2(RULE_SLOTS + 1);
  localparam int IDX_W   = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  ipal_pkg::token_t   chain [RULE_SLOTS+1];
  ipal_pkg::rule_wr_t wr;
  logic [IDX_W-1:0]   wr_idx;
  logic [COUNT_W-1:0] count;

  ipal_ctrl #(
    .RULE_SLOTS (RULE_SLOTS),
    .COUNT_W    (COUNT_W),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .head      (chain[0]),
    .tail      (chain[RULE_SLOTS]),
    .count     (count),
    .wr        (wr),
    .wr_idx    (wr_idx)
  );

  // Cell i holds rule i; a new rule goes into the cell at the current count.
  for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
    ipal_cell #(
      .IDX     (i),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .count  (count),
      .wr     (wr),
      .wr_sel (wr_idx == IDX_W'(i)),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

endmodule

`default_nettype wire

// File: bench/ipv4_prefix_acl_table_tb.sv
`timescale 1ns / 1ps

import ipal_pkg::*;

// Mirror of the rule table. It applies every accepted request to its own copy
// of the rules, queues the response that request must produce, and compares
// each response taken from the block against the oldest queued one.
class acl_rule_mirror #(parameter int SLOTS = 16);
  logic [ADDR_W-1:0] rule_base[SLOTS];
  logic [ADDR_W-1:0] rule_mask[SLOTS];
  int unsigned       rule_total;
  out_rsp_t          pending_rsp[$];
  int unsigned       error_count;

  function new();
    rule_total  = 0;
    error_count = 0;
  endfunction

  // Lengths above the address width act as a full host mask; zero keeps no bit.
  function logic [ADDR_W-1:0] prefix_mask(logic [5:0] plen);
    int unsigned keep;
    keep = (plen > ADDR_W) ? ADDR_W : plen;
    return ~({ADDR_W{1'b1}} >> keep);
  endfunction

  function void note_request(in_req_t req);
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] b;
    out_rsp_t          rsp;
    bit                seen;
    seen = 1'b0;
    if (req.kind == KIND_ADD) begin
      m = prefix_mask(req.prefix_len);
      b = req.address & m;
      for (int i = 0; i < rule_total; i++) begin
        if (rule_base[i] == b && rule_mask[i] == m) begin
          seen = 1'b1;
        end
      end
      // The duplicate check wins over the capacity check.
      if (seen) begin
        rsp.status = STAT_DUP;
      end else if (rule_total >= SLOTS) begin
        rsp.status = STAT_FULL;
      end else begin
        rule_base[rule_total] = b;
        rule_mask[rule_total] = m;
        rule_total++;
        rsp.status = STAT_OK;
      end
    end else begin
      rsp.status = STAT_NOT_FOUND;
      for (int i = 0; i < rule_total; i++) begin
        if ((req.address & rule_mask[i]) == rule_base[i]) begin
          rsp.status = STAT_OK;
        end
      end
    end
    rsp.rule_count = 5'(rule_total);
    pending_rsp.push_back(rsp);
  endfunction

  // Printing stops after the first hundred, counting does not.
  task report_mismatch(string msg);
    error_count++;
    if (error_count <= 100) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  task check_response(out_rsp_t got);
    out_rsp_t want;
    if (pending_rsp.size() == 0) begin
      report_mismatch($sformatf("response with no request waiting: status %0d count %0d",
                                got.status, got.rule_count));
    end else begin
      want = pending_rsp.pop_front();
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
      if (got.rule_count !== want.rule_count) begin
        report_mismatch($sformatf("rule count %0d, expected %0d",
                                  got.rule_count, want.rule_count));
      end
    end
  endtask
endclass

module ipv4_prefix_acl_table_tb;

  localparam int RULE_SLOTS = 16;
  // One request walks the whole row of cells before its response is ready.
  localparam int WALK_CYCLES = RULE_SLOTS + 3;
  // The slowest correct run is far below this: about 800 requests, each
  // taking the walk, the sender's idle cycles and a long receiver stall.
  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  acl_rule_mirror #(RULE_SLOTS) sb;

  // Idle rates in percent. The sender rate is the chance per cycle that the
  // sender holds its next request back; the receiver rate is the chance per
  // cycle that ready stays low.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;

  ipv4_prefix_acl_table #(
    .RULE_SLOTS(RULE_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver throttles itself at random, including while reset is held.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every response the block hands over is checked at the edge that takes it.
  // Values read here are those from before the edge, so the order of
  // processes within the step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_response(out_data);
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ipv4_prefix_acl_table_tb: done, errors");
      $finish;
    end
  end

  function automatic in_req_t make_req(logic kind, logic [ADDR_W-1:0] addr,
                                       logic [5:0] plen);
    in_req_t r;
    r.kind       = kind;
    r.address    = addr;
    r.prefix_len = plen;
    return r;
  endfunction

  // Prefix length for a fresh rule. Short prefixes cover a large part of the
  // address space, so they are kept rare to leave room for misses.
  function automatic logic [5:0] fresh_prefix();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      return 6'($urandom_range(1, 7));
    end else if (pick < 85) begin
      return 6'($urandom_range(8, 32));
    end
    return 6'($urandom_range(33, 63));
  endfunction

  // An address inside stored rule idx, with random host bits.
  function automatic logic [ADDR_W-1:0] covered_addr(int unsigned idx);
    return sb.rule_base[idx] | ($urandom & ~sb.rule_mask[idx]);
  endfunction

  // Add request: either a fresh random rule or an existing rule restated with
  // different host bits, which must come back as a duplicate.
  function automatic in_req_t make_add(bit fresh);
    int unsigned idx;
    int          len;
    logic [5:0]  plen;
    if (fresh || sb.rule_total == 0) begin
      return make_req(KIND_ADD, $urandom, fresh_prefix());
    end
    idx  = $urandom_range(sb.rule_total - 1);
    len  = $countones(sb.rule_mask[idx]);
    plen = (len == ADDR_W) ? 6'($urandom_range(32, 63)) : 6'(len);
    return make_req(KIND_ADD, covered_addr(idx), plen);
  endfunction

  // Test request: an address that some rule covers, a near miss with one
  // network bit of a rule flipped, or a fully random address.
  function automatic in_req_t make_test();
    int unsigned idx;
    int unsigned pick;
    int          len;
    logic [5:0]  junk_plen;
    junk_plen = 6'($urandom_range(63));
    pick      = $urandom_range(99);
    if (sb.rule_total == 0 || pick >= 60) begin
      return make_req(KIND_TEST, $urandom, junk_plen);
    end
    idx = $urandom_range(sb.rule_total - 1);
    len = $countones(sb.rule_mask[idx]);
    if (pick < 45 || len == 0) begin
      return make_req(KIND_TEST, covered_addr(idx), junk_plen);
    end
    return make_req(KIND_TEST,
                    covered_addr(idx) ^ (32'h1 << $urandom_range(31, ADDR_W - len)),
                    junk_plen);
  endfunction

  // Offers one request and holds it until the block takes it; the mirror
  // learns of the request at the edge that accepts it. Before the offer the
  // sender stays idle for each cycle in which its idle draw comes up.
  task automatic issue(in_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  // Sender holds off until every outstanding response has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_rsp.size() != 0);
  endtask

  // A stretch of random traffic. New rules are offered only while the table
  // holds fewer than fill_cap rules; beyond that, adds restate stored rules.
  task automatic run_phase(int unsigned items, int unsigned snd_pct, int unsigned rcv_pct,
                           int unsigned fill_cap);
    bit fresh;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int unsigned n = 0; n < items; n++) begin
      if (n == items / 2) begin
        drain();
      end
      if ($urandom_range(99) < 55) begin
        issue(make_test());
      end else begin
        fresh = ($urandom_range(99) < 30) && (sb.rule_total < fill_cap);
        issue(make_add(fresh));
      end
    end
  endtask

  initial begin
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 81;

    // Lookups on an empty table find nothing.
    issue(make_req(KIND_TEST, 32'h0000_0000, 6'd0));
    issue(make_req(KIND_TEST, 32'hFFFF_FFFF, 6'd63));
    // A full host rule, then the same rule with saturating lengths, which
    // must be rejected as duplicates.
    issue(make_req(KIND_ADD, 32'hFFFF_FFFF, 6'd32));
    issue(make_req(KIND_ADD, 32'hFFFF_FFFF, 6'd63));
    issue(make_req(KIND_ADD, 32'hFFFF_FFFF, 6'd33));
    issue(make_req(KIND_TEST, 32'hFFFF_FFFF, 6'd0));
    issue(make_req(KIND_TEST, 32'hFFFF_FFFE, 6'd32));
    // Host bits are dropped from the base: the second add is a duplicate,
    // while the first rule's base under a different mask is a new rule.
    issue(make_req(KIND_ADD, 32'hC0A8_0123, 6'd24));
    issue(make_req(KIND_ADD, 32'hC0A8_01FF, 6'd24));
    issue(make_req(KIND_ADD, 32'hC0A8_0100, 6'd23));
    issue(make_req(KIND_TEST, 32'hC0A8_00FE, 6'd7));
    issue(make_req(KIND_TEST, 32'hC0A9_0000, 6'd7));
    issue(make_req(KIND_ADD, 32'h0000_0001, 6'd31));
    issue(make_req(KIND_TEST, 32'h0000_0001, 6'd1));
    issue(make_req(KIND_TEST, 32'h0000_0002, 6'd1));
    issue(make_req(KIND_ADD, 32'h0A00_0000, 6'd8));
    issue(make_req(KIND_TEST, 32'h0AFF_FFFF, 6'd8));
    drain();

    run_phase(270, 20, 81, 8);
    drain();
    run_phase(270, 81, 20, RULE_SLOTS - 2);
    drain();

    // Last phase, no idling on either side. A prefix of zero gives a rule
    // that covers every address, so it waits until now; restating it with
    // another address is a duplicate. The table then fills, further new rules
    // report a full table, and restated rules stay duplicates even then.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    issue(make_req(KIND_ADD, $urandom, 6'd0));
    issue(make_req(KIND_ADD, ~32'h0, 6'd0));
    issue(make_req(KIND_TEST, $urandom, 6'd0));
    run_phase(260, 0, 0, RULE_SLOTS + 1);

    drain();
    repeat (WALK_CYCLES + 8) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("ipv4_prefix_acl_table_tb: done, clean");
    end else begin
      $display("ipv4_prefix_acl_table_tb: done, errors");
    end
    $finish;
  end

endmodule
